@@ hdl/cpuw_pkg.sv @@
package cpuw_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ANGLE_STEPS_DEF  = 16;
   localparam int GUARD_BITS       = 24;
   localparam int TABLE_SIZE       = 24;
   localparam int STEP_W           = 5;
   localparam int Z_W              = 32;
   localparam int PHASE_W          = 32;
   localparam int ANGLE_W          = 16;
   localparam int QUEUE_DEPTH      = 2;

   // per-sample flags carried from the classifier to the CORDIC engine
   typedef struct packed {
      logic zero;       // sample is (0,0)
      logic half_turn;  // vector was mirrored into the right half plane
      logic last;       // last sample of the run
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ITER  = 4'b0010,
      ST_ANGLE = 4'b0100,
      ST_EMIT  = 4'b1000
   } back_state_type;

   typedef struct packed {
      logic idle;
      logic emit_fire;
   } back_stat_type;

   // atan(2^-i) in units of 2^32 per turn
   function automatic logic [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/cpuw_front.sv @@
module cpuw_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int XW           = 43
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [SAMPLE_WIDTH-1:0]  real_part,
   input  logic [SAMPLE_WIDTH-1:0]  imag_part,
   input  logic                     last_in_run,
   input  logic                     q_full,
   output logic                     push,
   output logic [2*XW+cpuw_pkg::FLAGS_W-1:0] push_data
);
   import cpuw_pkg::*;

   localparam int PAD_W = XW - SAMPLE_WIDTH - GUARD_BITS;

   logic [XW-1:0] x_ext;
   logic [XW-1:0] y_ext;
   logic [XW-1:0] x_start;
   logic [XW-1:0] y_start;
   flags_type     flags;

   always_comb begin
      x_ext = {{PAD_W{real_part[SAMPLE_WIDTH-1]}}, real_part, {GUARD_BITS{1'b0}}};
      y_ext = {{PAD_W{imag_part[SAMPLE_WIDTH-1]}}, imag_part, {GUARD_BITS{1'b0}}};
      flags.half_turn = real_part[SAMPLE_WIDTH-1];
      flags.zero      = (real_part == '0) && (imag_part == '0);
      flags.last      = last_in_run;
      // mirror a left-half-plane vector so the engine starts with x >= 0
      x_start = flags.half_turn ? (~x_ext + 1'b1) : x_ext;
      y_start = flags.half_turn ? (~y_ext + 1'b1) : y_ext;
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign push_data  = {x_start, y_start, flags};

endmodule

@@ hdl/cpuw_queue.sv @@
module cpuw_queue #(
   parameter int W     = 89,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [W-1:0]               push_data,
   input  logic                       pop,
   output logic                       q_valid,
   output logic [W-1:0]               q_data,
   output logic                       q_full,
   output logic [$clog2(DEPTH+1)-1:0] q_count
);
   import cpuw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      do_push   = push && (count_ff != CNT_W'(DEPTH));
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_data  = mem_ff[rd_ptr_ff];
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_count = count_ff;

endmodule

@@ hdl/cpuw_back.sv @@
module cpuw_back #(
   parameter int XW          = 43,
   parameter int ANGLE_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  logic [2*XW+cpuw_pkg::FLAGS_W-1:0]    q_data,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cpuw_pkg::PHASE_W-1:0]         unwrapped_phase,
   output logic [cpuw_pkg::ANGLE_W-1:0]         wrapped_angle,
   output logic                                 run_end,
   output cpuw_pkg::back_stat_type              stat
);
   import cpuw_pkg::*;

   localparam int STEPS_DONE = (ANGLE_STEPS < TABLE_SIZE) ? ANGLE_STEPS : TABLE_SIZE;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_DONE - 1);

   back_state_type     state_ff, state_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [XW-1:0]      y_ff, y_in;
   logic [Z_W-1:0]     z_ff, z_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   flags_type          flags_ff, flags_in;
   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [ANGLE_W-1:0] prev_ff, prev_in;
   logic [PHASE_W-1:0] total_ff, total_in;
   logic               start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               y_neg;
   logic [XW-1:0]      y_mag;
   logic [XW-1:0]      y_sh;
   logic [XW-1:0]      x_sh;
   logic [Z_W-1:0]     z_step;
   logic [Z_W-1:0]     z_round;
   logic [ANGLE_W-1:0] diff;
   logic [PHASE_W:0]   sum;
   logic [PHASE_W-1:0] sat;
   logic [PHASE_W-1:0] phase;
   logic               out_free;
   logic               emit_fire;

   always_comb begin
      // one vectoring step; x stays non-negative, so only |y| needs care
      y_neg   = y_ff[XW-1];
      y_mag   = y_neg ? (~y_ff + 1'b1) : y_ff;
      y_sh    = y_mag >> cnt_ff;
      x_sh    = x_ff >> cnt_ff;
      z_step  = atan_step(cnt_ff);
      z_round = z_ff + Z_W'(32'h0000_8000);

      diff = angle_ff - prev_ff;
      sum  = {total_ff[PHASE_W-1], total_ff} + {{(PHASE_W-ANGLE_W+1){diff[ANGLE_W-1]}}, diff};
      if (sum[PHASE_W] != sum[PHASE_W-1]) begin
         sat = sum[PHASE_W] ? {1'b1, {(PHASE_W-1){1'b0}}} : {1'b0, {(PHASE_W-1){1'b1}}};
      end else begin
         sat = sum[PHASE_W-1:0];
      end
      phase = start_ff ? {{(PHASE_W-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff} : sat;

      out_free  = !rsp_valid_ff || rsp_tready;
      emit_fire = (state_ff == ST_EMIT) && out_free;
      pop       = (state_ff == ST_IDLE) && q_valid;

      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      cnt_in       = cnt_ff;
      flags_in     = flags_ff;
      angle_in     = angle_ff;
      prev_in      = prev_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_phase_in = rsp_phase_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               x_in     = q_data[2*XW+FLAGS_W-1 -: XW];
               y_in     = q_data[XW+FLAGS_W-1 -: XW];
               flags_in = q_data[FLAGS_W-1:0];
               z_in     = q_data[1] ? {1'b1, {(Z_W-1){1'b0}}} : '0;
               cnt_in   = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            x_in   = x_ff + y_sh;
            y_in   = y_neg ? (y_ff + x_sh) : (y_ff - x_sh);
            z_in   = y_neg ? (z_ff - z_step) : (z_ff + z_step);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            angle_in = flags_ff.zero ? '0 : z_round[Z_W-1 -: ANGLE_W];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               total_in     = phase;
               prev_in      = angle_ff;
               start_in     = flags_ff.last;
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase;
               rsp_angle_in = angle_ff;
               rsp_last_in  = flags_ff.last;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         total_ff     <= '0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      cnt_ff       <= cnt_in;
      flags_ff     <= flags_in;
      angle_ff     <= angle_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign unwrapped_phase = rsp_phase_ff;
   assign wrapped_angle   = rsp_angle_ff;
   assign run_end         = rsp_last_ff;
   assign stat.idle       = (state_ff == ST_IDLE);
   assign stat.emit_fire  = emit_fire;

endmodule

@@ hdl/complex_phase_unwrap.sv @@
// The iterative CORDIC engine works on one request at a time: load, one rotation per
// cycle, angle rounding, unwrap and result write.
// A two-entry queue takes further requests while the engine is busy.
// Reset: synchronous, active high; clears the queue, the run state and rsp_tvalid.
module complex_phase_unwrap #(
   parameter int SAMPLE_WIDTH = cpuw_pkg::SAMPLE_WIDTH_DEF,
   parameter int ANGLE_STEPS  = cpuw_pkg::ANGLE_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // real_part, imag_part, zero fill to whole bytes
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // unwrapped_phase, wrapped_angle
   output logic [47:0]                           rsp_tdata,
   output logic                                  rsp_tlast
);
   import cpuw_pkg::*;

   localparam int XW     = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int ENTRY_W = 2*XW + FLAGS_W;

   logic                             q_full;
   logic                             push;
   logic [ENTRY_W-1:0]               push_data;
   logic                             pop;
   logic                             q_valid;
   logic [ENTRY_W-1:0]               q_data;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [PHASE_W-1:0]               unwrapped_phase;
   logic [ANGLE_W-1:0]               wrapped_angle;
   back_stat_type                    stat;

   cpuw_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .XW          (XW)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .real_part  (req_tdata[SAMPLE_WIDTH-1:0]),
      .imag_part  (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .last_in_run(req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   cpuw_queue #(
      .W    (ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_full   (q_full),
      .q_count  (q_count)
   );

   cpuw_back #(
      .XW         (XW),
      .ANGLE_STEPS(ANGLE_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .unwrapped_phase(unwrapped_phase),
      .wrapped_angle  (wrapped_angle),
      .run_end        (rsp_tlast),
      .stat           (stat)
   );

   assign rsp_tdata = {wrapped_angle, unwrapped_phase};

   // a waiting request is picked up by an idle engine at once
   a_idle_picks_up: assert property (@(posedge clock) disable iff (reset)
      (stat.idle && q_valid) |=> !stat.idle)
      else $error("engine idle while queue holds a request");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (q_count != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("request accepted into a full queue");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.emit_fire))
      else $error("result shown without an unwrap step");

endmodule
